[rtl/dnp_pkg.sv]
// ----------------------------------------------------------------------------
// dnp_pkg
// Shared types and constants of the decimal number text parser: character
// classes, parse phases, result status codes and the queue item format.
// ----------------------------------------------------------------------------
package dnp_pkg;

   // Character codes the parser recognises
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
   localparam logic [7:0] CH_EXP_U = 8'h45;  // 'E'
   localparam logic [7:0] CH_EXP_L = 8'h65;  // 'e'
   localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
   localparam logic [7:0] CH_TAB   = 8'h09;  // horizontal tab

   // Mantissa accumulator limits: largest value that may still take a digit
   localparam logic [63:0] MANT_LIMIT   = 64'h1999_9999_9999_9999;
   localparam logic [3:0]  MANT_LAST_DG = 4'd5;
   localparam logic [7:0]  FRAC_MAX     = 8'hFF;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 88;

   // Result format register codes
   localparam logic [1:0] KIND_DOUBLE = 2'd0;
   localparam logic [1:0] KIND_SINGLE = 2'd1;
   localparam logic [1:0] KIND_OTHER  = 2'd2;

   typedef enum logic [2:0] {
      CLS_BLANK,
      CLS_DIGIT,
      CLS_DOT,
      CLS_EXP,
      CLS_MINUS,
      CLS_PLUS,
      CLS_OTHER
   } char_class_type;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_INT,
      PH_FRAC,
      PH_ESIGN,
      PH_EXP,
      PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD,
      ST_SIZE
   } status_type;

   // One classified character as it travels through the queue
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
      logic           empty;
   } item_type;

endpackage

[rtl/decimal_number_text_parser_core.sv]
// ----------------------------------------------------------------------------
// decimal_number_text_parser_core
// Streaming parser of decimal floating-point text into sign, decimal
// mantissa, fraction digit count and exponent.
// ----------------------------------------------------------------------------
// One character item is taken per clock cycle while the queue has room. A
// token's last character is written into the four-entry queue, and the parse
// engine then loads the result register from it; a finished result waiting
// to be taken can hold that load. The parse engine does the 64-bit
// multiply-by-ten-and-add of one digit per cycle while digits flow. Input
// stalls only when the queue is full, which happens only while a finished
// result waits to be taken.
// ----------------------------------------------------------------------------
module decimal_number_text_parser_core (
   input  logic                           clock,
   input  logic                           reset,
   // Result format register
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_wr_data,  // [1:0] target_kind
   // Character stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [dnp_pkg::REQ_DATA_W-1:0] req_tdata,    // [7:0] ch
   input  logic                           req_tlast,    // last
   input  logic                           req_tuser,    // [0] empty_req
   // Result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] negative, [64:1] mantissa, [65] mantissa_saturated,
   // [73:66] fraction_digits, [81:74] exponent_value, [82] exponent_negative
   output logic [dnp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser     // [1:0] status
);

   logic [1:0]        kind_ff;
   logic              queue_full, push, pop, pop_valid;
   dnp_pkg::item_type push_item, pop_item;

   // Result format register
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= dnp_pkg::KIND_DOUBLE;
      end else if (csr_wr_en) begin
         kind_ff <= csr_wr_data;
      end
   end

   dnp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   dnp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   dnp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .target_kind (kind_ff),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

[rtl/dnp_front.sv]
// ----------------------------------------------------------------------------
// dnp_front
// Input side: takes one character item when the queue has room and sorts the
// character into a class, with its digit value, before queueing it.
// ----------------------------------------------------------------------------
module dnp_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dnp_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] ch
   input  logic                              req_tlast,
   input  logic                              req_tuser,   // [0] empty_req
   input  logic                              queue_full,
   output logic                              push,
   output dnp_pkg::item_type                 push_item
);

   dnp_pkg::char_class_type cls;

   // Character classification
   always_comb begin
      if (req_tdata inside {[dnp_pkg::CH_ZERO:dnp_pkg::CH_NINE]}) begin
         cls = dnp_pkg::CLS_DIGIT;
      end else begin
         case (req_tdata)
            dnp_pkg::CH_SPACE,
            dnp_pkg::CH_TAB:   cls = dnp_pkg::CLS_BLANK;
            dnp_pkg::CH_DOT:   cls = dnp_pkg::CLS_DOT;
            dnp_pkg::CH_EXP_U,
            dnp_pkg::CH_EXP_L: cls = dnp_pkg::CLS_EXP;
            dnp_pkg::CH_MINUS: cls = dnp_pkg::CLS_MINUS;
            dnp_pkg::CH_PLUS:  cls = dnp_pkg::CLS_PLUS;
            default:           cls = dnp_pkg::CLS_OTHER;
         endcase
      end
   end

   // Handshake and queue write
   assign req_tready      = !queue_full;
   assign push            = req_tvalid && !queue_full;
   assign push_item.cls   = cls;
   assign push_item.digit = req_tdata[3:0];
   assign push_item.last  = req_tlast;
   assign push_item.empty = req_tuser;

endmodule

[rtl/dnp_queue.sv]
// ----------------------------------------------------------------------------
// dnp_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dnp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dnp_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output dnp_pkg::item_type pop_item
);

   dnp_pkg::item_type              slot_ff [dnp_pkg::QUEUE_DEPTH];
   logic [dnp_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dnp_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dnp_pkg::QUEUE_AW:0]     count_ff, count_in;

   localparam logic [dnp_pkg::QUEUE_AW:0] DEPTH_CNT = (dnp_pkg::QUEUE_AW+1)'(dnp_pkg::QUEUE_DEPTH);
   localparam logic [dnp_pkg::QUEUE_AW-1:0] LAST_SLOT =
      dnp_pkg::QUEUE_AW'(dnp_pkg::QUEUE_DEPTH - 1);

   assign full      = (count_ff == DEPTH_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue fill level above depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");
`endif

endmodule

[rtl/dnp_back.sv]
// ----------------------------------------------------------------------------
// dnp_back
// Parse engine: steps the token phase per classified item, accumulates the
// mantissa, fraction count and exponent, and registers one result per token.
// ----------------------------------------------------------------------------
module dnp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     target_kind,
   input  logic                           pop_valid,
   input  dnp_pkg::item_type              pop_item,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] negative, [64:1] mantissa, [65] mantissa_saturated,
   // [73:66] fraction_digits, [81:74] exponent_value, [82] exponent_negative
   output logic [dnp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser    // [1:0] status
);

   localparam logic [63:0] MANT_LIMIT_L = dnp_pkg::MANT_LIMIT;

   // Token state
   dnp_pkg::phase_type phase_ff, phase_in, ph_next;
   logic               bad_ff, bad_in, bad_next;
   logic               sign_ff, sign_in, sign_next;
   logic [63:0]        acc_ff, acc_in, acc_next;
   logic               sat_ff, sat_in, sat_next;
   logic [7:0]         frac_ff, frac_in, frac_next;
   logic [7:0]         exp_ff, exp_in, exp_next;
   logic               eneg_ff, eneg_in, eneg_next;

   // Result register
   logic               out_valid_ff, out_valid_in;
   dnp_pkg::status_type status_ff, status_in;
   logic               neg_ff, neg_in;
   logic [63:0]        mant_ff, mant_in;
   logic               msat_ff, msat_in;
   logic [7:0]         fdig_ff, fdig_in;
   logic [7:0]         eval_ff, eval_in;
   logic               eneg_out_ff, eneg_out_in;

   dnp_pkg::phase_type eff_phase;
   dnp_pkg::char_class_type cls;
   logic               ends, take, lead_blank, lead_sign;
   logic               add_dig, add_frac, add_exp;
   logic [63:0]        acc_x10;
   logic               acc_over;
   logic [7:0]         exp_x10;

   assign cls  = pop_item.cls;
   assign ends = pop_item.empty || pop_item.last;
   // Items that end a token need room in the result register
   assign pop  = pop_valid && (!ends || !out_valid_ff || rsp_tready);
   assign take = pop && !pop_item.empty && !bad_ff;

   assign lead_blank = (phase_ff == dnp_pkg::PH_LEAD) && (cls == dnp_pkg::CLS_BLANK);
   assign lead_sign  = (phase_ff == dnp_pkg::PH_LEAD) &&
                       (cls inside {dnp_pkg::CLS_MINUS, dnp_pkg::CLS_PLUS});
   // A first non-blank that is no sign is handled as an integer character
   assign eff_phase  = (phase_ff == dnp_pkg::PH_LEAD) ? dnp_pkg::PH_INT : phase_ff;

   // Phase and malformed flag, before any end-of-token clear
   always_comb begin
      ph_next  = phase_ff;
      bad_next = bad_ff;
      add_dig  = 1'b0;
      add_frac = 1'b0;
      add_exp  = 1'b0;
      if (take && !lead_blank) begin
         ph_next = eff_phase;
         if (lead_sign) begin
            ph_next = dnp_pkg::PH_INT;
         end else begin
            case (eff_phase)
               dnp_pkg::PH_INT: begin
                  case (cls)
                     dnp_pkg::CLS_DIGIT: add_dig  = 1'b1;
                     dnp_pkg::CLS_DOT:   ph_next  = dnp_pkg::PH_FRAC;
                     dnp_pkg::CLS_EXP:   ph_next  = dnp_pkg::PH_ESIGN;
                     dnp_pkg::CLS_BLANK: ph_next  = dnp_pkg::PH_TRAIL;
                     default:            bad_next = 1'b1;
                  endcase
               end
               dnp_pkg::PH_FRAC: begin
                  case (cls)
                     dnp_pkg::CLS_DIGIT: begin
                        add_dig  = 1'b1;
                        add_frac = 1'b1;
                     end
                     dnp_pkg::CLS_EXP:   ph_next  = dnp_pkg::PH_ESIGN;
                     dnp_pkg::CLS_BLANK: ph_next  = dnp_pkg::PH_TRAIL;
                     default:            bad_next = 1'b1;
                  endcase
               end
               dnp_pkg::PH_ESIGN: begin
                  case (cls)
                     dnp_pkg::CLS_PLUS,
                     dnp_pkg::CLS_MINUS: ph_next  = dnp_pkg::PH_EXP;
                     default:            bad_next = 1'b1;
                  endcase
               end
               dnp_pkg::PH_EXP: begin
                  case (cls)
                     dnp_pkg::CLS_DIGIT: add_exp  = 1'b1;
                     dnp_pkg::CLS_BLANK: ph_next  = dnp_pkg::PH_TRAIL;
                     default:            bad_next = 1'b1;
                  endcase
               end
               dnp_pkg::PH_TRAIL: begin
                  if (cls != dnp_pkg::CLS_BLANK) begin
                     bad_next = 1'b1;
                  end
               end
               default: bad_next = 1'b1;
            endcase
         end
      end
   end

   // Digit arithmetic: times ten as two shifts and an add
   assign acc_x10  = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0};
   assign acc_over = (acc_ff > MANT_LIMIT_L) ||
                     (acc_ff == MANT_LIMIT_L && pop_item.digit > dnp_pkg::MANT_LAST_DG);
   assign exp_x10  = {exp_ff[4:0], 3'b000} + {exp_ff[6:0], 1'b0};

   // Accumulators and signs
   always_comb begin
      sign_next = sign_ff;
      acc_next  = acc_ff;
      sat_next  = sat_ff;
      frac_next = frac_ff;
      exp_next  = exp_ff;
      eneg_next = eneg_ff;
      if (take && lead_sign && cls == dnp_pkg::CLS_MINUS) begin
         sign_next = 1'b1;
      end
      if (add_dig && !sat_ff) begin
         if (acc_over) begin
            acc_next = '1;
            sat_next = 1'b1;
         end else begin
            acc_next = acc_x10 + {60'd0, pop_item.digit};
         end
      end
      if (add_frac && frac_ff != dnp_pkg::FRAC_MAX) begin
         frac_next = frac_ff + 8'd1;
      end
      if (add_exp) begin
         exp_next = exp_x10 + {4'd0, pop_item.digit};
      end
      if (take && eff_phase == dnp_pkg::PH_ESIGN && !lead_sign) begin
         if (cls == dnp_pkg::CLS_MINUS) begin
            eneg_next = 1'b1;
         end else if (cls == dnp_pkg::CLS_PLUS) begin
            eneg_next = 1'b0;
         end
      end
   end

   // Token state update, cleared when a token ends and its result is loaded
   always_comb begin
      if (pop && ends) begin
         phase_in = dnp_pkg::PH_LEAD;
         bad_in   = 1'b0;
         sign_in  = 1'b0;
         acc_in   = '0;
         sat_in   = 1'b0;
         frac_in  = '0;
         exp_in   = '0;
         eneg_in  = 1'b0;
      end else begin
         phase_in = ph_next;
         bad_in   = bad_next;
         sign_in  = sign_next;
         acc_in   = acc_next;
         sat_in   = sat_next;
         frac_in  = frac_next;
         exp_in   = exp_next;
         eneg_in  = eneg_next;
      end
   end

   // Result register: loaded at token end, freed when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      neg_in       = neg_ff;
      mant_in      = mant_ff;
      msat_in      = msat_ff;
      fdig_in      = fdig_ff;
      eval_in      = eval_ff;
      eneg_out_in  = eneg_out_ff;
      if (pop && ends) begin
         out_valid_in = 1'b1;
         if (pop_item.empty || bad_next) begin
            status_in = dnp_pkg::ST_BAD;
         end else if (target_kind >= dnp_pkg::KIND_OTHER) begin
            status_in = dnp_pkg::ST_SIZE;
         end else begin
            status_in = dnp_pkg::ST_OK;
         end
         if (status_in == dnp_pkg::ST_OK) begin
            neg_in      = sign_next;
            mant_in     = acc_next;
            msat_in     = sat_next;
            fdig_in     = frac_next;
            eval_in     = exp_next;
            eneg_out_in = eneg_next;
         end else begin
            neg_in      = 1'b0;
            mant_in     = '0;
            msat_in     = 1'b0;
            fdig_in     = '0;
            eval_in     = '0;
            eneg_out_in = 1'b0;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dnp_pkg::PH_LEAD;
         bad_ff       <= 1'b0;
         sign_ff      <= 1'b0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         frac_ff      <= '0;
         exp_ff       <= '0;
         eneg_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bad_ff       <= bad_in;
         sign_ff      <= sign_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         frac_ff      <= frac_in;
         exp_ff       <= exp_in;
         eneg_ff      <= eneg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      neg_ff      <= neg_in;
      mant_ff     <= mant_in;
      msat_ff     <= msat_in;
      fdig_ff     <= fdig_in;
      eval_ff     <= eval_in;
      eneg_out_ff <= eneg_out_in;
   end

   // Output packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'd0, eneg_out_ff, eval_ff, fdig_ff, msat_ff, mant_ff, neg_ff};

`ifndef SYNTHESIS
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (pop && ends) |=> (phase_ff == dnp_pkg::PH_LEAD && !bad_ff && acc_ff == '0))
      else $error("token state not cleared after result");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && status_ff != dnp_pkg::ST_OK) |-> (mant_ff == '0 && !neg_ff))
      else $error("error result carries non-zero fields");

   a_saturated_all_ones: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (acc_ff == '1))
      else $error("saturated mantissa not at maximum");
`endif

endmodule
